// ===== design/repeating_decimal_expander_defines.svh =====
// Assertion macros used by the checker file of the decimal expander.
`ifndef REPEATING_DECIMAL_EXPANDER_DEFINES_SVH
`define REPEATING_DECIMAL_EXPANDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("expander check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("expander check failed");

`endif

// ===== design/rde_pkg.sv =====
// Types and constants of the repeating decimal expander.
package rde_pkg;

    localparam int MAX_DEN_DEF = 64;
    localparam int NUM_W_DEF   = 16;
    localparam int DEN_W       = 8;
    localparam int WHOLE_W     = 16;
    localparam int DIGIT_W     = 4;
    localparam int POS_W       = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WHOLE,
        S_FRAC,
        S_MARK,
        S_DIGIT,
        S_LOOK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_bad;
        logic whole_step;
        logic emit_none;
        logic mark;
        logic digit_step;
        logic look;
        logic emit_digit;
    } t_ctrl;

    typedef struct packed {
        logic bad;
        logic rem_zero;
        logic stop;
    } t_stat;

endpackage

// ===== design/rde_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module rde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rde_divstep.sv =====
// One restoring division step: shift in a bit, compare and subtract the divisor.
module rde_divstep #(
    parameter int REM_W  = 6,
    parameter int DMAG_W = 7
) (
    input  logic [REM_W-1:0]  i_part,
    input  logic              i_bit,
    input  logic [DMAG_W-1:0] i_divisor,
    output logic              o_quot_bit,
    output logic [REM_W-1:0]  o_part
);

    localparam int T_W = REM_W + 1;

    logic [T_W-1:0] trial;
    logic [T_W-1:0] divisor_ext;
    logic [T_W-1:0] diff;

    assign trial       = {i_part, i_bit};
    assign divisor_ext = T_W'(i_divisor);
    assign diff        = trial - divisor_ext;
    assign o_quot_bit  = (trial >= divisor_ext);
    assign o_part      = o_quot_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];

endmodule

// ===== design/rde_ctrl.sv =====
// Sequencer of the expander: whole-part steps, a remainder check, then mark, digit steps, lookup, emit.
module rde_ctrl
    import rde_pkg::*;
#(
    parameter int NUM_W = NUM_W_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy
);

    localparam int CNT_W = $clog2(NUM_W);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start && !i_stat.bad) n_state = S_WHOLE;
            S_WHOLE: if (r_cnt == CNT_W'(NUM_W - 1)) n_state = S_FRAC;
            S_FRAC:  n_state = i_stat.rem_zero ? S_IDLE : S_MARK;
            S_MARK:  n_state = S_DIGIT;
            S_DIGIT: if (r_cnt == CNT_W'(DIGIT_W - 1)) n_state = S_LOOK;
            S_LOOK:  n_state = S_EMIT;
            S_EMIT:  n_state = i_stat.stop ? S_IDLE : S_MARK;
            default: n_state = S_IDLE;
        endcase
    end

    // Step counter: restart on entry to each multi-cycle state.
    always_comb begin
        if (r_state == S_WHOLE || r_state == S_DIGIT) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_cnt = '0;
        end
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.load     = i_start && !i_stat.bad;
                o_ctrl.emit_bad = i_start && i_stat.bad;
            end
            S_WHOLE: o_ctrl.whole_step = 1'b1;
            S_FRAC:  o_ctrl.emit_none  = i_stat.rem_zero;
            S_MARK:  o_ctrl.mark       = 1'b1;
            S_DIGIT: o_ctrl.digit_step = 1'b1;
            S_LOOK:  o_ctrl.look       = 1'b1;
            S_EMIT:  o_ctrl.emit_digit = 1'b1;
            default: o_ctrl = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== design/repeating_decimal_expander.sv =====
// Decimal expander: whole-part division over the NUMERATOR_WIDTH numerator bits, then a
// remainder check, then per fractional digit a mark, 4 division steps, a lookup and an emit.
// A bad denominator gives its result in the cycle after start. One divide step
// unit is shared by the whole-part and digit steps.
// Each result shows for one cycle on o_valid; no stall.
// Synchronous active-low reset returns the sequencer to idle and drops o_valid.
module repeating_decimal_expander
    import rde_pkg::*;
#(
    parameter int MAX_DENOMINATOR = MAX_DEN_DEF,
    parameter int NUMERATOR_WIDTH = NUM_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [NUMERATOR_WIDTH-1:0] i_numerator,
    input  logic signed [DEN_W-1:0]           i_denominator,
    output logic                              o_valid,
    output logic                              o_negative,
    output logic [WHOLE_W-1:0]                o_whole_part,
    output logic                              o_has_digit,
    output logic [DIGIT_W-1:0]                o_digit,
    output logic [POS_W-1:0]                  o_digit_position,
    output logic                              o_repeats,
    output logic [POS_W-1:0]                  o_period_start,
    output logic                              o_bad_denominator,
    output logic                              o_last
);

    localparam int NW     = NUMERATOR_WIDTH;
    localparam int REM_W  = $clog2(MAX_DENOMINATOR);
    localparam int DMAG_W = $clog2(MAX_DENOMINATOR + 1);
    localparam int R10_W  = REM_W + DIGIT_W;

    t_ctrl ctl;
    t_stat stat;

    logic [NW-1:0]     nmag;
    logic [DEN_W-1:0]  dmag;
    logic              neg_in;
    logic              step_bit;
    logic              step_q;
    logic [REM_W-1:0]  step_part;
    logic [R10_W-1:0]  r10;
    logic [POS_W-1:0]  ram_rdata;
    logic              rep;

    logic [NW-1:0]              r_nmag, n_nmag;
    logic [DMAG_W-1:0]          r_dmag, n_dmag;
    logic                       r_neg, n_neg;
    logic [NW-1:0]              r_quot, n_quot;
    logic [REM_W-1:0]           r_rem, n_rem;
    logic [DIGIT_W-1:0]         r_low, n_low;
    logic [DIGIT_W-1:0]         r_dig, n_dig;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic                       r_stop, n_stop;
    logic [MAX_DENOMINATOR-1:0] r_seen, n_seen;

    logic               r_o_valid, n_o_valid;
    logic               r_o_neg, n_o_neg;
    logic [WHOLE_W-1:0] r_o_whole, n_o_whole;
    logic               r_o_has, n_o_has;
    logic [DIGIT_W-1:0] r_o_digit, n_o_digit;
    logic [POS_W-1:0]   r_o_pos, n_o_pos;
    logic               r_o_rep, n_o_rep;
    logic [POS_W-1:0]   r_o_pstart, n_o_pstart;
    logic               r_o_bad, n_o_bad;
    logic               r_o_last, n_o_last;

    assign nmag   = i_numerator[NW-1] ? NW'(-i_numerator) : NW'(i_numerator);
    assign dmag   = i_denominator[DEN_W-1] ? DEN_W'(-i_denominator) : DEN_W'(i_denominator);
    assign neg_in = (i_numerator != '0) && (i_numerator[NW-1] != i_denominator[DEN_W-1]);

    assign stat.bad      = (dmag == '0) || (dmag > DEN_W'(MAX_DENOMINATOR));
    assign stat.rem_zero = (r_rem == '0);
    assign stat.stop     = r_stop;

    assign r10      = (R10_W'(r_rem) << 3) + (R10_W'(r_rem) << 1);
    assign step_bit = ctl.digit_step ? r_low[DIGIT_W-1] : r_nmag[NW-1];
    assign rep      = r_stop && (r_rem != '0);

    rde_ctrl #(
        .NUM_W (NW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctl),
        .o_busy  (busy)
    );

    rde_divstep #(
        .REM_W  (REM_W),
        .DMAG_W (DMAG_W)
    ) u_step (
        .i_part     (r_rem),
        .i_bit      (step_bit),
        .i_divisor  (r_dmag),
        .o_quot_bit (step_q),
        .o_part     (step_part)
    );

    // First digit index of each remainder met in this item.
    rde_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_DENOMINATOR)
    ) u_first_pos (
        .i_clk   (i_clk),
        .i_we    (ctl.mark),
        .i_waddr (r_rem),
        .i_wdata (r_pos),
        .i_raddr (r_rem),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_nmag = r_nmag;
        n_dmag = r_dmag;
        n_neg  = r_neg;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_low  = r_low;
        n_dig  = r_dig;
        n_pos  = r_pos;
        n_stop = r_stop;
        n_seen = r_seen;
        if (ctl.load) begin
            n_nmag = nmag;
            n_dmag = dmag[DMAG_W-1:0];
            n_neg  = neg_in;
            n_quot = '0;
            n_rem  = '0;
            n_pos  = '0;
            n_seen = '0;
        end
        if (ctl.whole_step) begin
            n_nmag = r_nmag << 1;
            n_quot = {r_quot[NW-2:0], step_q};
            n_rem  = step_part;
        end
        if (ctl.mark) begin
            n_seen[r_rem] = 1'b1;
            n_rem         = r10[R10_W-1:DIGIT_W];
            n_low         = r10[DIGIT_W-1:0];
        end
        if (ctl.digit_step) begin
            n_rem = step_part;
            n_low = r_low << 1;
            n_dig = {r_dig[DIGIT_W-2:0], step_q};
        end
        if (ctl.look) begin
            n_stop = (r_rem == '0) || r_seen[r_rem];
        end
        if (ctl.emit_digit) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_comb begin
        n_o_valid  = ctl.emit_bad || ctl.emit_none || ctl.emit_digit;
        n_o_neg    = r_o_neg;
        n_o_whole  = r_o_whole;
        n_o_has    = r_o_has;
        n_o_digit  = r_o_digit;
        n_o_pos    = r_o_pos;
        n_o_rep    = r_o_rep;
        n_o_pstart = r_o_pstart;
        n_o_bad    = r_o_bad;
        n_o_last   = r_o_last;
        if (ctl.emit_bad) begin
            n_o_neg    = 1'b0;
            n_o_whole  = '0;
            n_o_has    = 1'b0;
            n_o_digit  = '0;
            n_o_pos    = '0;
            n_o_rep    = 1'b0;
            n_o_pstart = '0;
            n_o_bad    = 1'b1;
            n_o_last   = 1'b1;
        end else if (ctl.emit_none || ctl.emit_digit) begin
            n_o_neg    = r_neg;
            n_o_whole  = WHOLE_W'(r_quot);
            n_o_has    = ctl.emit_digit;
            n_o_digit  = ctl.emit_digit ? r_dig : '0;
            n_o_pos    = ctl.emit_digit ? r_pos : '0;
            n_o_rep    = ctl.emit_digit && rep;
            n_o_pstart = (ctl.emit_digit && rep) ? ram_rdata : '0;
            n_o_bad    = 1'b0;
            n_o_last   = ctl.emit_none || r_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_seen    <= '0;
        end else begin
            r_o_valid <= n_o_valid;
            r_seen    <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nmag     <= n_nmag;
        r_dmag     <= n_dmag;
        r_neg      <= n_neg;
        r_quot     <= n_quot;
        r_rem      <= n_rem;
        r_low      <= n_low;
        r_dig      <= n_dig;
        r_pos      <= n_pos;
        r_stop     <= n_stop;
        r_o_neg    <= n_o_neg;
        r_o_whole  <= n_o_whole;
        r_o_has    <= n_o_has;
        r_o_digit  <= n_o_digit;
        r_o_pos    <= n_o_pos;
        r_o_rep    <= n_o_rep;
        r_o_pstart <= n_o_pstart;
        r_o_bad    <= n_o_bad;
        r_o_last   <= n_o_last;
    end

    assign o_valid           = r_o_valid;
    assign o_negative        = r_o_neg;
    assign o_whole_part      = r_o_whole;
    assign o_has_digit       = r_o_has;
    assign o_digit           = r_o_digit;
    assign o_digit_position  = r_o_pos;
    assign o_repeats         = r_o_rep;
    assign o_period_start    = r_o_pstart;
    assign o_bad_denominator = r_o_bad;
    assign o_last            = r_o_last;

endmodule

// ===== design/rde_checker.sv =====
// Port-level checks of the decimal expander, bound to the top level.
`include "repeating_decimal_expander_defines.svh"

module rde_checker
    import rde_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic               o_negative,
    input logic [WHOLE_W-1:0] o_whole_part,
    input logic               o_has_digit,
    input logic               o_repeats,
    input logic [POS_W-1:0]   o_period_start,
    input logic               o_bad_denominator,
    input logic               o_last
);

    // a word that is not last must carry a digit, and more words must follow
    `RDE_ASSERT_NOW(a_mid_word, i_clk, i_rst_n, o_valid && !o_last, o_has_digit && busy)
    // a bad denominator gives one bare word
    `RDE_ASSERT_NOW(a_bad_word, i_clk, i_rst_n, o_valid && o_bad_denominator, o_last && !o_has_digit && !o_negative && (o_whole_part == '0))
    // a period is reported only on the last digit word
    `RDE_ASSERT_NOW(a_repeat_last, i_clk, i_rst_n, o_valid && o_repeats, o_last && o_has_digit && !o_bad_denominator)
    `RDE_ASSERT_NOW(a_pstart_zero, i_clk, i_rst_n, o_valid && !o_repeats, o_period_start == '0)
    // an accepted item with a good denominator keeps the block busy
    `RDE_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, start && !busy && !o_valid && $past(!busy), busy || o_valid)

endmodule

bind repeating_decimal_expander rde_checker u_rde_checker (.*);
